// File: rtl/core/fbik_pkg.sv
// ----------------------------------------------------------------------------
// fbik_pkg
// Types, codes and constants shared by the five-bar leg inverse kinematics
// controller, datapath and top level.
// ----------------------------------------------------------------------------
package fbik_pkg;

    typedef struct packed {
        logic signed [19:0] foot_x;
        logic signed [19:0] foot_y;
        logic signed [19:0] roll_offset;
    } fbik_in_t;

    typedef struct packed {
        logic signed [15:0] left_front_angle;
        logic signed [15:0] left_back_angle;
        logic signed [15:0] right_front_angle;
        logic signed [15:0] right_back_angle;
        logic               left_ok;
        logic               right_ok;
    } fbik_out_t;

    typedef struct packed {
        logic [9:0] front_crank_length;
        logic [9:0] front_rod_length;
        logic [9:0] back_rod_length;
        logic [9:0] back_crank_length;
        logic [9:0] hip_spacing;
    } fbik_cfg_t;

    localparam logic [2:0] REG_FRONT_CRANK = 3'd0;
    localparam logic [2:0] REG_FRONT_ROD   = 3'd1;
    localparam logic [2:0] REG_BACK_ROD    = 3'd2;
    localparam logic [2:0] REG_BACK_CRANK  = 3'd3;
    localparam logic [2:0] REG_HIP_SPACING = 3'd4;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_SETUP,
        DP_MUL_PX,
        DP_MUL_PY,
        DP_MUL_SUM,
        DP_MUL_DIF,
        DP_MUL_DISC,
        DP_SQRT,
        DP_MUL_A,
        DP_MUL_B,
        DP_MUL_C1,
        DP_MUL_C2,
        DP_FORM,
        DP_NORM,
        DP_CORDIC,
        DP_ANGLE,
        DP_FINISH,
        DP_FAIL,
        DP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MPX,
        ST_MPY,
        ST_MSUM,
        ST_MDIF,
        ST_MDISC,
        ST_SQRT,
        ST_MA,
        ST_MB,
        ST_MC1,
        ST_MC2,
        ST_FORM,
        ST_NORM,
        ST_CORDIC,
        ST_ANGLE,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        logic       side;
        logic       loop;
        logic [4:0] iter;
    } fbik_cmd_t;

    typedef struct packed {
        logic range_fail;
        logic zero_fail;
        logic norm_done;
    } fbik_status_t;

    localparam int SQRT_STEPS   = 30;
    localparam int CORDIC_STEPS = 16;

    localparam logic signed [21:0] ANG_3_49  = 22'sd228721;
    localparam logic signed [21:0] ANG_0_349 = 22'sd22872;
    localparam logic signed [21:0] ANG_2PI   = 22'sd411776;
    localparam logic signed [21:0] WIN_LO    = -22'sd6554;
    localparam logic signed [21:0] WIN_HI    = 22'sd101581;
    localparam logic signed [43:0] NORM_LIM  = 44'sd549755813888;

    function automatic logic [15:0] atan_entry(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30385;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/fbik_dp.sv
// ----------------------------------------------------------------------------
// fbik_dp
// Datapath: shared multiplier, bit-pair square root, normalizer, CORDIC
// vectoring stage, angle window check, held angles and output register.
// ----------------------------------------------------------------------------
module fbik_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fbik_pkg::fbik_cmd_t  cmd,
    input  fbik_pkg::fbik_cfg_t  cfg,
    input  fbik_pkg::fbik_in_t   in_item,
    output fbik_pkg::fbik_status_t status,
    output fbik_pkg::fbik_out_t  out_item
);
    import fbik_pkg::*;

    logic signed [19:0] x_reg, y_reg, r_reg;
    logic signed [21:0] px_reg, py_reg;
    logic [14:0]        crank_reg, rod_reg;
    logic [43:0]        d2_reg;
    logic [29:0]        sum2_reg, dif2_reg;
    logic [59:0]        rem_reg, root_reg, bit_reg;
    logic signed [44:0] a_reg, b_reg, c_reg;
    logic signed [43:0] ny_reg, nx_reg;
    logic signed [18:0] z_reg;
    logic signed [19:0] tf_reg, tb_reg;
    logic signed [15:0] held_reg [4];
    logic [1:0]         ok_reg;
    fbik_out_t          out_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [15:0]        sum_w;
    logic signed [15:0] dif_w;
    logic [29:0]        e1_w, e2_w;
    logic [59:0]        trial_w;
    logic signed [45:0] s_w, num_w, den_w;
    logic signed [43:0] xs_w, ys_w;
    logic signed [18:0] tab_w;
    logic signed [21:0] hip8_w, ysum_w, ydif_w;
    logic signed [21:0] a1_w, a2_w, a1w_w, a2w_w;
    logic signed [15:0] r1_w, r2_w;
    logic               win_ok;

    assign sum_w  = 16'(crank_reg) + 16'(rod_reg);
    assign dif_w  = $signed(16'(crank_reg)) - $signed(16'(rod_reg));
    assign e1_w   = 30'(44'(sum2_reg) - d2_reg);
    assign e2_w   = 30'(d2_reg - 44'(dif2_reg));
    assign hip8_w = $signed({9'd0, cfg.hip_spacing, 3'd0});
    assign ysum_w = 22'(y_reg) + 22'(r_reg);
    assign ydif_w = 22'(y_reg) - 22'(r_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            DP_MUL_PX: begin
                mul_a = 33'(px_reg);
                mul_b = 33'(px_reg);
            end
            DP_MUL_PY: begin
                mul_a = 33'(py_reg);
                mul_b = 33'(py_reg);
            end
            DP_MUL_SUM: begin
                mul_a = $signed(33'(sum_w));
                mul_b = $signed(33'(sum_w));
            end
            DP_MUL_DIF: begin
                mul_a = 33'(dif_w);
                mul_b = 33'(dif_w);
            end
            DP_MUL_DISC: begin
                mul_a = $signed(33'(e1_w));
                mul_b = $signed(33'(e2_w));
            end
            DP_MUL_A: begin
                mul_a = 33'(px_reg);
                mul_b = $signed(33'(crank_reg));
            end
            DP_MUL_B: begin
                mul_a = 33'(py_reg);
                mul_b = $signed(33'(crank_reg));
            end
            DP_MUL_C1: begin
                mul_a = $signed(33'(crank_reg));
                mul_b = $signed(33'(crank_reg));
            end
            DP_MUL_C2: begin
                mul_a = $signed(33'(rod_reg));
                mul_b = $signed(33'(rod_reg));
            end
            default: ;
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign trial_w = root_reg + bit_reg;
    assign s_w     = $signed({15'd0, root_reg[30:0]});
    assign num_w   = cmd.loop ? (46'(b_reg) - s_w) : (46'(b_reg) + s_w);
    assign den_w   = 46'(a_reg) + 46'(c_reg);
    assign xs_w    = nx_reg >>> cmd.iter[3:0];
    assign ys_w    = ny_reg >>> cmd.iter[3:0];
    assign tab_w   = $signed(19'(atan_entry(cmd.iter[3:0])));

    assign a1_w  = ANG_3_49 - 22'(tf_reg);
    assign a2_w  = ANG_0_349 + 22'(tb_reg);
    assign a1w_w = (a1_w >= ANG_2PI) ? a1_w - ANG_2PI : a1_w;
    assign a2w_w = (a2_w >= ANG_2PI) ? a2_w - ANG_2PI : a2_w;
    assign win_ok = (a1w_w > WIN_LO) && (a1w_w < WIN_HI) &&
                    (a2w_w > WIN_LO) && (a2w_w < WIN_HI);
    assign r1_w  = 16'((a1w_w + 22'sd4) >>> 3);
    assign r2_w  = 16'((a2w_w + 22'sd4) >>> 3);

    assign status.range_fail = (d2_reg > 44'(sum2_reg)) || (d2_reg < 44'(dif2_reg));
    assign status.zero_fail  = (num_w == '0) && (den_w == '0);
    assign status.norm_done  = !((ny_reg < NORM_LIM) && (ny_reg > -NORM_LIM) &&
                                 (nx_reg < NORM_LIM));

    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_LOAD: begin
                x_reg <= in_item.foot_x;
                y_reg <= in_item.foot_y;
                r_reg <= in_item.roll_offset;
            end
            DP_SETUP: begin
                px_reg    <= cmd.loop ? 22'(x_reg) - hip8_w : 22'(x_reg) + hip8_w;
                py_reg    <= cmd.side ? ydif_w : ysum_w;
                crank_reg <= cmd.loop ? {cfg.back_crank_length, 4'd0}
                                      : {cfg.front_crank_length, 4'd0};
                rod_reg   <= cmd.loop ? {cfg.back_rod_length, 4'd0}
                                      : {cfg.front_rod_length, 4'd0};
            end
            DP_MUL_PX:  d2_reg   <= prod[43:0];
            DP_MUL_PY:  d2_reg   <= d2_reg + prod[43:0];
            DP_MUL_SUM: sum2_reg <= prod[29:0];
            DP_MUL_DIF: dif2_reg <= prod[29:0];
            DP_MUL_DISC: begin
                rem_reg  <= prod[59:0];
                root_reg <= '0;
                bit_reg  <= 60'(1) << (2 * (SQRT_STEPS - 1));
            end
            DP_SQRT: begin
                if (rem_reg >= trial_w) begin
                    rem_reg  <= rem_reg - trial_w;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            DP_MUL_A:  a_reg <= 45'(prod[43:0]) <<< 1;
            DP_MUL_B:  b_reg <= 45'(prod[43:0]) <<< 1;
            DP_MUL_C1: c_reg <= $signed({1'b0, d2_reg}) + 45'(prod[43:0]);
            DP_MUL_C2: c_reg <= c_reg - 45'(prod[43:0]);
            DP_FORM: begin
                if (den_w < 0) begin
                    ny_reg <= 44'(-num_w);
                    nx_reg <= 44'(-den_w);
                end else begin
                    ny_reg <= 44'(num_w);
                    nx_reg <= 44'(den_w);
                end
                z_reg <= '0;
            end
            DP_NORM: begin
                ny_reg <= ny_reg <<< 1;
                nx_reg <= nx_reg <<< 1;
            end
            DP_CORDIC: begin
                if (ny_reg >= 0) begin
                    nx_reg <= nx_reg + ys_w;
                    ny_reg <= ny_reg - xs_w;
                    z_reg  <= z_reg + tab_w;
                end else begin
                    nx_reg <= nx_reg - ys_w;
                    ny_reg <= ny_reg + xs_w;
                    z_reg  <= z_reg - tab_w;
                end
            end
            DP_ANGLE: begin
                if (cmd.loop) begin
                    tb_reg <= {z_reg, 1'b0};
                end else begin
                    tf_reg <= {z_reg, 1'b0};
                end
            end
            DP_OUT: begin
                out_reg.left_front_angle  <= held_reg[0];
                out_reg.left_back_angle   <= held_reg[1];
                out_reg.right_front_angle <= held_reg[2];
                out_reg.right_back_angle  <= held_reg[3];
                out_reg.left_ok           <= ok_reg[0];
                out_reg.right_ok          <= ok_reg[1];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                held_reg[k] <= '0;
            end
            ok_reg <= '0;
        end else begin
            case (cmd.op)
                DP_FAIL: ok_reg[cmd.side] <= 1'b0;
                DP_FINISH: begin
                    ok_reg[cmd.side] <= win_ok;
                    if (win_ok) begin
                        if (cmd.side) begin
                            held_reg[2] <= r2_w;
                            held_reg[3] <= -r1_w;
                        end else begin
                            held_reg[0] <= -r2_w;
                            held_reg[1] <= r1_w;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_item = out_reg;

endmodule

// File: rtl/core/fbik_ctrl.sv
// ----------------------------------------------------------------------------
// fbik_ctrl
// Sequencer: walks both sides of each item, and both loops of a side unless
// one fails, through the datapath and runs the input and result handshakes.
// ----------------------------------------------------------------------------
module fbik_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  fbik_pkg::fbik_status_t status,
    output fbik_pkg::fbik_cmd_t    cmd
);
    import fbik_pkg::*;

    state_t     state_reg, state_next;
    logic       side_reg, side_next;
    logic       loop_reg, loop_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            side_reg    <= 1'b0;
            loop_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            side_reg    <= side_next;
            loop_reg    <= loop_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        side_next    = side_reg;
        loop_next    = loop_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SETUP;
                    side_next  = 1'b0;
                    loop_next  = 1'b0;
                end
            end
            ST_SETUP: state_next = ST_MPX;
            ST_MPX:   state_next = ST_MPY;
            ST_MPY:   state_next = ST_MSUM;
            ST_MSUM:  state_next = ST_MDIF;
            ST_MDIF:  state_next = ST_MDISC;
            ST_MDISC: begin
                if (status.range_fail) begin
                    loop_next  = 1'b0;
                    side_next  = 1'b1;
                    state_next = side_reg ? ST_OUT : ST_SETUP;
                end else begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_STEPS - 1)) begin
                    state_next = ST_MA;
                end
            end
            ST_MA:  state_next = ST_MB;
            ST_MB:  state_next = ST_MC1;
            ST_MC1: state_next = ST_MC2;
            ST_MC2: state_next = ST_FORM;
            ST_FORM: begin
                if (status.zero_fail) begin
                    loop_next  = 1'b0;
                    side_next  = 1'b1;
                    state_next = side_reg ? ST_OUT : ST_SETUP;
                end else begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if (status.norm_done) begin
                    cnt_next   = '0;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1)) begin
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                if (loop_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    loop_next  = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_FINISH: begin
                loop_next  = 1'b0;
                side_next  = 1'b1;
                state_next = side_reg ? ST_OUT : ST_SETUP;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op   = DP_NOP;
        cmd.side = side_reg;
        cmd.loop = loop_reg;
        cmd.iter = cnt_reg;
        s_ready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = DP_LOAD;
                end
            end
            ST_SETUP:  cmd.op = DP_SETUP;
            ST_MPX:    cmd.op = DP_MUL_PX;
            ST_MPY:    cmd.op = DP_MUL_PY;
            ST_MSUM:   cmd.op = DP_MUL_SUM;
            ST_MDIF:   cmd.op = DP_MUL_DIF;
            ST_MDISC:  cmd.op = status.range_fail ? DP_FAIL : DP_MUL_DISC;
            ST_SQRT:   cmd.op = DP_SQRT;
            ST_MA:     cmd.op = DP_MUL_A;
            ST_MB:     cmd.op = DP_MUL_B;
            ST_MC1:    cmd.op = DP_MUL_C1;
            ST_MC2:    cmd.op = DP_MUL_C2;
            ST_FORM:   cmd.op = status.zero_fail ? DP_FAIL : DP_FORM;
            ST_NORM:   cmd.op = status.norm_done ? DP_NOP : DP_NORM;
            ST_CORDIC: cmd.op = DP_CORDIC;
            ST_ANGLE:  cmd.op = DP_ANGLE;
            ST_FINISH: cmd.op = DP_FINISH;
            ST_OUT:    cmd.op = (!m_valid_reg || m_ready) ? DP_OUT : DP_NOP;
            default:   cmd.op = DP_NOP;
        endcase
    end

    assign m_valid = m_valid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SETUP && !side_reg && !loop_reg))
        else $error("accepted item did not start on the left front loop");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_OUT) |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while holding an item");

    a_sqrt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |-> (cnt_reg < 5'(SQRT_STEPS)))
        else $error("square root step count overrun");

    a_cordic_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORDIC) |-> (cnt_reg < 5'(CORDIC_STEPS)))
        else $error("CORDIC step count overrun");

endmodule

// File: rtl/core/five_bar_leg_inverse_kinematics.sv
// Throughput: one item at a time, set by the shared multiplier, the one
//   bit-pair-per-cycle square root and the 16-step CORDIC stage.
// Reset: synchronous active low; link registers return to their defaults,
//   held angles clear to zero and no result is pending.
// ----------------------------------------------------------------------------
// five_bar_leg_inverse_kinematics
// Top level: APB register file, sequencer and datapath for left and right
// five-bar leg angles from a foot target and a roll offset.
// ----------------------------------------------------------------------------
module five_bar_leg_inverse_kinematics (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fbik_pkg::fbik_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fbik_pkg::fbik_out_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import fbik_pkg::*;

    fbik_cfg_t    cfg_reg;
    fbik_cmd_t    cmd;
    fbik_status_t status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.front_crank_length <= 10'd150;
            cfg_reg.front_rod_length   <= 10'd288;
            cfg_reg.back_rod_length    <= 10'd288;
            cfg_reg.back_crank_length  <= 10'd150;
            cfg_reg.hip_spacing        <= 10'd150;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_FRONT_CRANK: cfg_reg.front_crank_length <= pwdata[9:0];
                REG_FRONT_ROD:   cfg_reg.front_rod_length   <= pwdata[9:0];
                REG_BACK_ROD:    cfg_reg.back_rod_length    <= pwdata[9:0];
                REG_BACK_CRANK:  cfg_reg.back_crank_length  <= pwdata[9:0];
                REG_HIP_SPACING: cfg_reg.hip_spacing        <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_FRONT_CRANK: prdata = {22'd0, cfg_reg.front_crank_length};
            REG_FRONT_ROD:   prdata = {22'd0, cfg_reg.front_rod_length};
            REG_BACK_ROD:    prdata = {22'd0, cfg_reg.back_rod_length};
            REG_BACK_CRANK:  prdata = {22'd0, cfg_reg.back_crank_length};
            REG_HIP_SPACING: prdata = {22'd0, cfg_reg.hip_spacing};
            default:         prdata = '0;
        endcase
    end

    fbik_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fbik_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .in_item  (s_data),
        .status   (status),
        .out_item (m_data)
    );

endmodule
